/* rtl/osp_pkg.sv */
// shared types and constants for the oled shadow pixel writer
// no dependencies; imported by the front, queue, back and top level

package osp_pkg;

    // panel defaults (pixels)
    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;

    // page index width covers up to 128 rows (16 pages of 8 rows)
    localparam int PAGE_W = 4;

    localparam int QUEUE_DEPTH = 2;

    // controller control bytes
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    // controller command encodings
    localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] COL_LOW_MASK  = 8'h0f;

    // beat order of one pixel update
    localparam logic [2:0] BEAT_PAGE_A = 3'd0;
    localparam logic [2:0] BEAT_HIGH_A = 3'd1;
    localparam logic [2:0] BEAT_LOW_A  = 3'd2;
    localparam logic [2:0] BEAT_PAGE_B = 3'd3;
    localparam logic [2:0] BEAT_HIGH_B = 3'd4;
    localparam logic [2:0] BEAT_LOW_B  = 3'd5;
    localparam logic [2:0] BEAT_DATA   = 3'd6;

    // classified pixel request handed from front to back
    typedef struct packed {
        logic [7:0]        column;
        logic [PAGE_W-1:0] page;
        logic [2:0]        bit_sel;
        logic              turn_on;
    } osp_req_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_EMIT
    } osp_state_t;

endpackage

/* rtl/osp_front.sv */
// front end: accepts pixel beats, drops off-panel requests, splits row into page and bit
// depends on osp_pkg

module osp_front #(
    parameter int PANEL_WIDTH  = osp_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = osp_pkg::DEF_PANEL_HEIGHT
) (
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // column[7:0], row[15:8], turn_on[16], zero pad
    input  logic              queue_full,
    input  logic              back_ready,
    output logic              push,
    output osp_pkg::osp_req_t push_req
);
    import osp_pkg::*;

    logic [7:0] column;
    logic [7:0] row;
    logic       in_panel;

    assign column = s_axis_tdata[7:0];
    assign row    = s_axis_tdata[15:8];

    assign in_panel = ({1'b0, column} < 9'(PANEL_WIDTH)) && ({1'b0, row} < 9'(PANEL_HEIGHT));

    // no beats taken until the shadow clear has finished
    assign s_axis_tready = !queue_full && back_ready;
    assign push          = s_axis_tvalid && s_axis_tready && in_panel;

    always_comb
    begin
        push_req.column  = column;
        push_req.page    = row[PAGE_W+2:3];
        push_req.bit_sel = row[2:0];
        push_req.turn_on = s_axis_tdata[16];
    end

endmodule

/* rtl/osp_queue.sv */
// small request queue between front and back
// depends on osp_pkg

module osp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  osp_pkg::osp_req_t push_req,
    input  logic              pop,
    output osp_pkg::osp_req_t head,
    output logic              full,
    output logic              empty
);
    import osp_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    osp_req_t           entry_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg;
    logic [IDX_W-1:0]   wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* rtl/osp_back.sv */
// back end: shadow ram, read-modify-write of one byte, seven-beat transaction sequencer
// depends on osp_pkg; holds the batch_mode register

module osp_back #(
    parameter int PANEL_WIDTH  = osp_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = osp_pkg::DEF_PANEL_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  osp_pkg::osp_req_t head,
    input  logic              queue_empty,
    output logic              pop,
    output logic              back_ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // payload[7:0]
    output logic [7:0]        m_axis_tuser,   // control_byte[7:0]
    output logic              m_axis_tlast    // last
);
    import osp_pkg::*;

    localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
    localparam int DEPTH      = PAGE_COUNT * PANEL_WIDTH;
    localparam int ADDR_W     = $clog2(DEPTH);

    logic [7:0]        shadow_mem [DEPTH];
    logic [7:0]        rd_data_reg;

    osp_state_t        state_reg;
    osp_state_t        state_next;
    logic [2:0]        beat_reg;
    logic [2:0]        beat_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              batch_mode_reg;

    osp_req_t          req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        new_byte_reg;

    logic [ADDR_W-1:0] head_addr;
    logic [7:0]        bit_mask;
    logic [7:0]        updated;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wdata;

    // page-major byte address: page * width + column
    assign head_addr = ADDR_W'(32'(head.page) * PANEL_WIDTH + 32'(head.column));

    assign bit_mask = 8'b1 << req_reg.bit_sel;
    assign updated  = req_reg.turn_on ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);

    assign back_ready = (state_reg != ST_CLEAR);

    always_comb
    begin
        state_next    = state_reg;
        beat_next     = beat_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wr_addr   = addr_reg;
        mem_wdata     = updated;
        pop           = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wdata   = '0;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    mem_re     = 1'b1;
                    pop        = 1'b1;
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                state_next = ST_IDLE;
                if (updated != rd_data_reg)
                begin
                    mem_we = 1'b1;
                    if (!batch_mode_reg)
                    begin
                        state_next = ST_EMIT;
                        beat_next  = BEAT_PAGE_A;
                    end
                end
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (beat_reg == BEAT_DATA)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        beat_next = beat_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    // beat payload decoded from the sequencer count
    always_comb
    begin
        unique case (beat_reg)
            BEAT_PAGE_A, BEAT_PAGE_B:
            begin
                m_axis_tuser = CTRL_COMMAND;
                m_axis_tdata = CMD_PAGE_BASE + {{(8-PAGE_W){1'b0}}, req_reg.page};
            end
            BEAT_HIGH_A, BEAT_HIGH_B:
            begin
                m_axis_tuser = CTRL_COMMAND;
                m_axis_tdata = CMD_COL_HIGH | {4'b0, req_reg.column[7:4]};
            end
            BEAT_LOW_A, BEAT_LOW_B:
            begin
                m_axis_tuser = CTRL_COMMAND;
                m_axis_tdata = req_reg.column & COL_LOW_MASK;
            end
            default:
            begin
                m_axis_tuser = CTRL_DATA;
                m_axis_tdata = new_byte_reg;
            end
        endcase
    end

    assign m_axis_tlast = (beat_reg == BEAT_DATA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            beat_reg       <= BEAT_PAGE_A;
            clr_addr_reg   <= '0;
            batch_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            beat_reg     <= beat_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_we)
            begin
                batch_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            req_reg  <= head;
            addr_reg <= head_addr;
        end
        if (state_reg == ST_MODIFY)
        begin
            new_byte_reg <= updated;
        end
    end

    // shadow ram: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shadow_mem[mem_wr_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= shadow_mem[head_addr];
        end
    end

endmodule

/* rtl/oled_shadow_pixel_writer.sv */
// top level of the oled shadow pixel writer: front, request queue and back
// depends on osp_pkg, osp_front, osp_queue, osp_back
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: column, row, turn_on
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: payload, tuser: control_byte, tlast
// cfg       in   cfg_we (no wait)                cfg_wdata: batch_mode
//
// after reset the shadow ram is zeroed, one byte a cycle (1024 bytes at 128x64),
// and s_axis_tready stays low until that pass is done
// the back end handles an on-panel pixel as a ram read, then a compare and write;
// a changed pixel outside batch mode adds seven m_axis beats, one per cycle without stalls
// the two-entry queue keeps taking beats while m_axis is stalled, until it is full

module oled_shadow_pixel_writer #(
    parameter int PANEL_WIDTH  = osp_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = osp_pkg::DEF_PANEL_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column[7:0], row[15:8], turn_on[16], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // payload[7:0]
    output logic [7:0]  m_axis_tuser,   // control_byte[7:0]
    output logic        m_axis_tlast    // last
);
    import osp_pkg::*;

    osp_req_t push_req;
    osp_req_t head;
    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_empty;
    logic     back_ready;

    osp_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .queue_full    (queue_full),
        .back_ready    (back_ready),
        .push          (push),
        .push_req      (push_req)
    );

    osp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    osp_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .head          (head),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .back_ready    (back_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* verif/osp_shadow_checker.sv */
// checker for the oled shadow pixel writer: keeps its own shadow of the panel ram,
// predicts the controller beats of every accepted pixel and compares them on m_axis
// depends on osp_pkg for the control bytes and command encodings

module osp_shadow_checker #(
    parameter int PANEL_WIDTH  = osp_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = osp_pkg::DEF_PANEL_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column[7:0], row[15:8], turn_on[16], zero pad
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // payload[7:0]
    input  logic [7:0]  m_axis_tuser,   // control_byte[7:0]
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          outstanding
);

    localparam int PAGES      = (PANEL_HEIGHT + 7) / 8;
    localparam int DEPTH      = PAGES * PANEL_WIDTH;

    typedef struct packed {
        logic [7:0] ctrl;
        logic [7:0] payload;
        logic       last;
    } ctrl_beat_t;

    logic [7:0] shadow [DEPTH];
    logic       batch;
    ctrl_beat_t beat_q [$];

    function automatic ctrl_beat_t make_beat(input logic [7:0] ctrl, input logic [7:0] payload,
                                             input logic last);
        ctrl_beat_t b;
        b.ctrl    = ctrl;
        b.payload = payload;
        b.last    = last;
        return b;
    endfunction

    // read-modify-write of the shadow byte; beats only for a changed byte outside batch
    task automatic apply_pixel(input logic [7:0] col, input logic [7:0] row, input logic on);
        logic [7:0] pg;
        int         slot;
        logic [7:0] mask;
        logic [7:0] prior;
        logic [7:0] next;
        logic [7:0] cmd_page;
        logic [7:0] cmd_hi;
        logic [7:0] cmd_lo;
        if (col >= PANEL_WIDTH || row >= PANEL_HEIGHT)
            return;
        pg    = {3'b000, row[7:3]};
        slot  = pg * PANEL_WIDTH + col;
        mask  = 8'h01 << row[2:0];
        prior = shadow[slot];
        next  = on ? (prior | mask) : (prior & ~mask);
        if (next == prior)
            return;
        shadow[slot] = next;
        if (batch)
            return;
        cmd_page = osp_pkg::CMD_PAGE_BASE + pg;
        cmd_hi   = osp_pkg::CMD_COL_HIGH | {4'h0, col[7:4]};
        cmd_lo   = col & osp_pkg::COL_LOW_MASK;
        repeat (2)
        begin
            beat_q.insert(beat_q.size(), make_beat(osp_pkg::CTRL_COMMAND, cmd_page, 1'b0));
            beat_q.insert(beat_q.size(), make_beat(osp_pkg::CTRL_COMMAND, cmd_hi, 1'b0));
            beat_q.insert(beat_q.size(), make_beat(osp_pkg::CTRL_COMMAND, cmd_lo, 1'b0));
        end
        beat_q.insert(beat_q.size(), make_beat(osp_pkg::CTRL_DATA, next, 1'b1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ctrl_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                shadow[i] = 8'h00;
            batch = 1'b0;
            beat_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                batch = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (beat_q.size() == 0)
                begin
                    $display("%0t unexpected beat: ctrl %h payload %h last %b", $time,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = beat_q.pop_front();
                    if (want.ctrl !== m_axis_tuser || want.payload !== m_axis_tdata
                        || want.last !== m_axis_tlast)
                    begin
                        $display("%0t mismatch: expected %h %h %b, got %h %h %b", $time,
                                 want.ctrl, want.payload, want.last,
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[16]);
            outstanding <= beat_q.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// testbench top for the oled shadow pixel writer: clock, reset, pixel stimulus,
// m_axis back-pressure and the verdict; depends on osp_pkg, the rtl and osp_shadow_checker

module tb_top;

    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_wdata     = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata  = '0;    // column[7:0], row[15:8], turn_on[16], zero pad
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [7:0]  m_axis_tdata;          // payload[7:0]
    wire  [7:0]  m_axis_tuser;          // control_byte[7:0]
    wire         m_axis_tlast;

    int   mismatches;
    int   outstanding;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    logic hold_req     = 1'b0;
    int   hold_cnt     = 0;
    int   stall_cycles = 0;

    always #5 clk = ~clk;

    oled_shadow_pixel_writer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    osp_shadow_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // receiver: one long hold-off when asked, otherwise random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req && hold_cnt < HOLD_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_pixel(input logic [7:0] col, input logic [7:0] row, input logic on);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0000000, on, row, col};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop offering and wait for the last beat plus the back end's own latency
    task automatic drain_beats();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_batch(input logic on);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mix of full-range coordinates (mostly off-panel), a dense corner that hits unchanged bytes, and the whole panel
    task automatic send_random(input int count);
        int         pick;
        logic [7:0] col;
        logic [7:0] row;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                col = 8'($urandom_range(255));
                row = 8'($urandom_range(255));
            end
            else if (pick < 50)
            begin
                col = 8'($urandom_range(3));
                row = 8'($urandom_range(15));
            end
            else
            begin
                col = 8'($urandom_range(127));
                row = 8'($urandom_range(63));
            end
            send_pixel(col, row, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // shadow clearing pass holds off the input after reset
        while (!s_axis_tready)
            @(posedge clk);
        set_batch(1'b0);

        // panel corners, then an already-set pixel and a double clear
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd127, 8'd63, 1'b1);
        send_pixel(8'd127, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd63, 1'b1);
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 1'b0);
        // just off the panel on the right and bottom edges, and one far corner
        send_pixel(8'd128, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd64, 1'b1);
        send_pixel(8'd127, 8'd64, 1'b0);
        send_pixel(8'd128, 8'd63, 1'b1);
        // every bit of one byte, then one cleared again
        for (int b = 0; b < 8; b++)
            send_pixel(8'h5a, 8'd16 + b[7:0], 1'b1);
        send_pixel(8'h5a, 8'd19, 1'b0);
        send_pixel(8'h35, 8'd47, 1'b1);

        // batch mode only fills the shadow; later writes must see that content
        drain_beats();
        set_batch(1'b1);
        send_pixel(8'd10, 8'd10, 1'b1);
        send_pixel(8'd10, 8'd10, 1'b1);
        send_pixel(8'd100, 8'd40, 1'b1);
        send_pixel(8'd200, 8'd5, 1'b1);
        drain_beats();
        set_batch(1'b0);
        send_pixel(8'd10, 8'd10, 1'b1);
        send_pixel(8'd10, 8'd10, 1'b0);
        send_pixel(8'd100, 8'd40, 1'b0);

        tx_idle_pct = 37;
        rx_idle_pct <= 79;
        send_random(30);
        drain_beats();
        send_random(30);

        drain_beats();
        set_batch(1'b1);
        send_random(20);
        drain_beats();
        set_batch(1'b0);

        tx_idle_pct = 79;
        rx_idle_pct <= 37;
        send_random(40);

        drain_beats();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= 1'b1;
        send_random(30);

        drain_beats();
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* oled_shadow_pixel_writer.f */
rtl/osp_pkg.sv
rtl/osp_front.sv
rtl/osp_queue.sv
rtl/osp_back.sv
rtl/oled_shadow_pixel_writer.sv
verif/osp_shadow_checker.sv
verif/tb_top.sv
